### rtl/core/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg
// Shared types and constants of the centered moving average unit.
// ----------------------------------------------------------------------------
package cma_pkg;

  // width of the half-width configuration port
  localparam int unsigned HALF_WIDTH_BITS = 4;

  // quotient bits resolved per divider cycle
  localparam int unsigned DIV_DIGIT_BITS = 4;

  // controller -> datapath
  typedef struct packed {
    logic cfg_write;  // load half width, clear stream
    logic accept;     // take the input sample into ring and sum
    logic start;      // launch divide and oldest-sample read
    logic commit;     // load result register, slide the window
    logic clear;      // drop stream state
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_item;   // current item closes the stream
    logic pending;     // window holds outputs not yet emitted
    logic take_emit;   // regular output due for this item
    logic final_item;  // output in flight is the stream's last
    logic div_done;    // quotient ready
    logic out_free;    // result register can take a value
  } status_t;

endpackage

### rtl/core/cma_ram.sv
// ----------------------------------------------------------------------------
// cma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cma_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/cma_div.sv
// ----------------------------------------------------------------------------
// cma_div
// Unsigned restoring divider, several quotient bits per cycle.
// ----------------------------------------------------------------------------
module cma_div #(
  parameter int unsigned DVD_W = 21,
  parameter int unsigned DVS_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int unsigned RB    = cma_pkg::DIV_DIGIT_BITS;
  localparam int unsigned STEPS = (DVD_W + RB - 1) / RB;
  localparam int unsigned PAD_W = STEPS * RB;
  localparam int unsigned RW    = DVS_W + 1;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic [PAD_W-1:0] quo;
  logic [PAD_W-1:0] quo_next;
  logic [RW-1:0]    rem;
  logic [RW-1:0]    rem_next;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  // dividend shifts out at the top while quotient bits enter at the bottom
  always_comb begin
    logic [RW-1:0]    r;
    logic [PAD_W-1:0] q;
    r = rem;
    q = quo;
    for (int j = 0; j < RB; j++) begin
      r = {r[RW-2:0], q[PAD_W-1]};
      q = {q[PAD_W-2:0], 1'b0};
      if (r >= {1'b0, dvs}) begin
        r    = r - {1'b0, dvs};
        q[0] = 1'b1;
      end
    end
    rem_next = r;
    quo_next = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      quo  <= PAD_W'(dividend);
      rem  <= '0;
      dvs  <= divisor;
      cnt  <= CNT_W'(STEPS);
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quotient = quo[DVD_W-1:0];

endmodule

### rtl/core/cma_dp.sv
// ----------------------------------------------------------------------------
// cma_dp
// Datapath: sample ring, running window sum, edge bookkeeping, divider
// and result register.
// ----------------------------------------------------------------------------
module cma_dp #(
  parameter int unsigned MAX_HALF    = 15,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cma_pkg::cmd_t                       cmd,
  output cma_pkg::status_t                    status,
  input  logic [cma_pkg::HALF_WIDTH_BITS-1:0] half_width,
  input  logic [SAMPLE_BITS-1:0]              sample,
  input  logic                                is_last,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [SAMPLE_BITS-1:0]              average,
  output logic                                last_out
);

  localparam int unsigned RING    = 2 * MAX_HALF + 1;
  localparam int unsigned RING_AW = $clog2(RING);
  localparam int unsigned SEEN_W  = $clog2(RING + 1);
  localparam int unsigned SUM_W   = SAMPLE_BITS + $clog2(RING);
  localparam int unsigned HW_W    = $clog2(MAX_HALF + 1);
  localparam int unsigned CMP_W   = SEEN_W + 2;
  localparam int unsigned CFG_W   = cma_pkg::HALF_WIDTH_BITS;
  localparam int unsigned CW      = (HW_W > CFG_W) ? HW_W : CFG_W;
  localparam int unsigned EXT_W   = SUM_W - SAMPLE_BITS;

  logic [HW_W-1:0]        hw;
  logic [RING_AW-1:0]     wptr;
  logic [SUM_W-1:0]       sum;
  logic [SEEN_W-1:0]      seen;
  logic [HW_W-1:0]        idx;
  logic [HW_W-1:0]        n;
  logic                   last_q;
  logic                   final_q;
  logic                   neg_q;
  logic                   zero_q;

  logic [HW_W-1:0]        left;
  logic [CMP_W-1:0]       gap;
  logic                   final_now;
  logic [RING_AW:0]       pos_raw;
  logic [RING_AW-1:0]     pos;
  logic [RING_AW-1:0]     wptr_next;
  logic [CW-1:0]          cfg_ext;
  logic [CW-1:0]          cfg_clamp;
  logic [SUM_W-1:0]       mag;
  logic [SUM_W-1:0]       quo;
  logic                   div_done;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [SAMPLE_BITS-1:0] q_low;
  logic [SAMPLE_BITS-1:0] avg;

  // outputs before half_width use the shorter left edge
  assign left      = (idx < hw) ? idx : hw;
  assign gap       = CMP_W'(seen) - CMP_W'(left);
  assign final_now = last_q && ((gap == CMP_W'(1)) || (n == HW_W'(MAX_HALF)));

  // oldest sample in the window sits seen entries behind the write pointer
  assign pos_raw = (RING_AW + 1)'(wptr) + (RING_AW + 1)'(RING) - (RING_AW + 1)'(seen);
  assign pos     = (pos_raw >= (RING_AW + 1)'(RING)) ?
                   RING_AW'(pos_raw - (RING_AW + 1)'(RING)) : pos_raw[RING_AW-1:0];

  assign wptr_next = (wptr == RING_AW'(RING - 1)) ? '0 : wptr + 1'b1;

  assign cfg_ext   = CW'(half_width);
  assign cfg_clamp = (cfg_ext > CW'(MAX_HALF)) ? CW'(MAX_HALF) : cfg_ext;

  assign mag = sum[SUM_W-1] ? (~sum + 1'b1) : sum;

  cma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (wptr),
    .wdata (sample),
    .re    (cmd.start),
    .raddr (pos),
    .rdata (old_sample)
  );

  cma_div #(
    .DVD_W (SUM_W),
    .DVS_W (SEEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start),
    .dividend (mag),
    .divisor  (seen),
    .done     (div_done),
    .quotient (quo)
  );

  // truncate toward zero: divide magnitudes, then restore the sign
  assign q_low = quo[SAMPLE_BITS-1:0];
  assign avg   = zero_q ? '0 : (neg_q ? (~q_low + 1'b1) : q_low);

  always_ff @(posedge clk) begin
    if (rst) begin
      hw           <= HW_W'(1);
      wptr         <= '0;
      sum          <= '0;
      seen         <= '0;
      idx          <= '0;
      n            <= '0;
      last_q       <= 1'b0;
      final_q      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (cmd.cfg_write) begin
        hw   <= cfg_clamp[HW_W-1:0];
        sum  <= '0;
        seen <= '0;
        idx  <= '0;
      end
      if (cmd.accept) begin
        wptr   <= wptr_next;
        sum    <= sum + {{EXT_W{sample[SAMPLE_BITS-1]}}, sample};
        seen   <= seen + 1'b1;
        last_q <= is_last;
        n      <= '0;
      end
      if (cmd.start) begin
        final_q <= final_now;
        neg_q   <= sum[SUM_W-1];
        zero_q  <= (seen == '0);
      end
      if (cmd.commit) begin
        average      <= avg;
        last_out     <= final_q;
        result_valid <= 1'b1;
        // slide the window once the left edge is full
        if (idx >= hw && seen != '0) begin
          sum  <= sum - {{EXT_W{old_sample[SAMPLE_BITS-1]}}, old_sample};
          seen <= seen - 1'b1;
        end
        if (idx != HW_W'(MAX_HALF)) begin
          idx <= idx + 1'b1;
        end
        n <= n + 1'b1;
      end
      if (cmd.clear) begin
        sum  <= '0;
        seen <= '0;
        idx  <= '0;
      end
    end
  end

  assign status.last_item  = last_q;
  assign status.pending    = CMP_W'(seen) > CMP_W'(left);
  assign status.take_emit  = (gap - CMP_W'(1)) == CMP_W'(hw);
  assign status.final_item = final_q;
  assign status.div_done   = div_done;
  assign status.out_free   = !result_valid || !result_stall;

endmodule

### rtl/core/cma_ctrl.sv
// ----------------------------------------------------------------------------
// cma_ctrl
// Controller: sequences accept, edge check, divide and result transfer.
// ----------------------------------------------------------------------------
module cma_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  output cma_pkg::cmd_t     cmd,
  input  cma_pkg::status_t  status
);

  typedef enum logic [1:0] {
    IDLE,
    CHECK,
    EMIT,
    DIVIDE
  } state_t;

  state_t state;

  // hold the input while a register write is offered
  assign sample_stall = (state != IDLE) || cfg_valid;
  assign cfg_ready    = (state == IDLE);

  always_comb begin
    cmd           = '0;
    cmd.cfg_write = cfg_valid && cfg_ready;
    cmd.accept    = sample_valid && !sample_stall;
    cmd.start     = (state == EMIT);
    unique case (state)
      IDLE: begin
      end
      CHECK: begin
        cmd.clear = status.last_item && !status.pending;
      end
      EMIT: begin
      end
      DIVIDE: begin
        if (status.div_done && status.out_free) begin
          cmd.commit = 1'b1;
          cmd.clear  = status.last_item && status.final_item;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (sample_valid && !sample_stall) begin
            state <= CHECK;
          end
        end
        CHECK: begin
          if (status.last_item) begin
            state <= status.pending ? EMIT : IDLE;
          end else begin
            state <= status.take_emit ? EMIT : IDLE;
          end
        end
        EMIT: begin
          state <= DIVIDE;
        end
        DIVIDE: begin
          // hold until the quotient is ready and the result register frees up
          if (status.div_done && status.out_free) begin
            if (status.last_item && !status.final_item) begin
              state <= EMIT;
            end else begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/centered_moving_average_unit.sv
// ----------------------------------------------------------------------------
// centered_moving_average_unit
// Centered moving average over a finite sample stream with truncated edges.
//
//   channel   handshake                   payload
//   -------   -------------------------   -------------------------------
//   cfg       cfg_valid / cfg_ready       half_width [3:0]
//   input     sample_valid / sample_stall sample [SAMPLE_BITS], is_last
//   result    result_valid / result_stall average [SAMPLE_BITS], last_out
//
// An item with no result passes CHECK and returns to IDLE. Each result also
// passes EMIT and DIVIDE, where the shared 4-bit-per-cycle divider works on a
// SUM_W-bit dividend, SUM_W = SAMPLE_BITS + clog2(2*MAX_HALF+1) (21 at the
// default sizes), and DIVIDE also waits for the result register to free up.
// A last item flushes up to half_width+1 results back to back in the same way.
// Reset is synchronous; half_width returns to 1 and the stream starts empty.
// A stalled result register holds the divider's result until its transfer.
// The input stalls while a register write is offered.
// ----------------------------------------------------------------------------
module centered_moving_average_unit #(
  parameter int unsigned MAX_HALF    = 15,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cma_pkg::HALF_WIDTH_BITS-1:0] half_width,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic [SAMPLE_BITS-1:0]              sample,
  input  logic                                is_last,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [SAMPLE_BITS-1:0]              average,
  output logic                                last_out
);

  cma_pkg::cmd_t    cmd;
  cma_pkg::status_t status;

  cma_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cmd          (cmd),
    .status       (status)
  );

  cma_dp #(
    .MAX_HALF    (MAX_HALF),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .half_width   (half_width),
    .sample       (sample),
    .is_last      (is_last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .average      (average),
    .last_out     (last_out)
  );

endmodule

### tb/sv/tb_centered_moving_average_unit.sv
// ----------------------------------------------------------------------------
// tb_centered_moving_average_unit
// Self-checking bench for the centered moving average unit. A predictor keeps
// its own copy of the sample window and stream state. It works out the
// averages that every accepted sample should release. A monitor compares each
// result transfer with the oldest of them. Streams run under several
// half-width settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_centered_moving_average_unit;

  localparam int unsigned MAX_HALF    = 15;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned RING        = 2 * MAX_HALF + 1;
  localparam int unsigned HW_BITS     = cma_pkg::HALF_WIDTH_BITS;
  localparam int unsigned IDLE_PCT    = 38;
  localparam int unsigned SETTLE      = 40;    // cycles for the block to go quiet
  localparam int unsigned QUIET_LIMIT = 4000;  // cycles with no transfer at all
  localparam int unsigned RANDOM_ITEMS = 350;
  localparam int unsigned PHASE_ITEMS  = 40;

  class window_average_predictor;
    typedef struct {
      logic [SAMPLE_BITS-1:0] avg;
      logic                   last;
    } average_t;

    average_t    expected_averages[$];
    int unsigned half;
    longint      window[RING];
    longint      sum;
    int unsigned seen;
    int unsigned out_idx;
    int unsigned wptr;
    int unsigned mismatches;
    int unsigned checked;

    function new();
      half = 1;
      wptr = 0;
      foreach (window[k]) window[k] = 0;
      clear_window();
      mismatches = 0;
      checked = 0;
    endfunction

    function void clear_window();
      sum = 0;
      seen = 0;
      out_idx = 0;
    endfunction

    function int unsigned left_edge();
      return (out_idx < half) ? out_idx : half;
    endfunction

    function void load_half_width(int unsigned v);
      half = (v > MAX_HALF) ? MAX_HALF : v;
      clear_window();
    endfunction

    // Queue the current average, then slide the oldest sample out once the
    // left edge is full.
    function void push_average(logic fin);
      longint      q;
      int unsigned pos;
      average_t    e;
      q = (seen != 0) ? sum / longint'(seen) : 0;
      e.avg = q[SAMPLE_BITS-1:0];
      e.last = fin;
      expected_averages = {expected_averages, e};
      if (out_idx >= half && seen != 0) begin
        pos = (wptr + RING - (seen % RING)) % RING;
        sum -= window[pos];
        seen--;
      end
      if (out_idx < 32'hFFFF) out_idx++;
    endfunction

    function void note_sample(logic [SAMPLE_BITS-1:0] s, logic last);
      int unsigned n;
      logic        fin;
      logic        done;
      window[wptr] = longint'($signed(s));
      wptr = (wptr + 1) % RING;
      sum += longint'($signed(s));
      seen++;
      if (last) begin
        // flush every pending output; the final one carries last_out
        n = 0;
        done = 0;
        while (!done && seen > left_edge() && n < MAX_HALF + 1) begin
          fin = (seen - left_edge() == 1) || (n == MAX_HALF);
          push_average(fin);
          n++;
          done = fin;
        end
        clear_window();
      end else if (seen - left_edge() - 1 == half) begin
        push_average(1'b0);
      end
    endfunction

    function void check_average(logic [SAMPLE_BITS-1:0] avg, logic last);
      average_t e;
      if (expected_averages.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected average: expected none, actual %0d last %0b",
                 $time, $signed(avg), last);
      end else begin
        e = expected_averages.pop_front();
        checked++;
        if (e.avg !== avg) begin
          mismatches++;
          $display("%0t: average mismatch: expected %0d, actual %0d",
                   $time, $signed(e.avg), $signed(avg));
        end
        if (e.last !== last) begin
          mismatches++;
          $display("%0t: last_out mismatch: expected %0b, actual %0b",
                   $time, e.last, last);
        end
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [HW_BITS-1:0]     half_width;
  logic                   sample_valid;
  logic                   sample_stall;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   is_last;
  logic                   result_valid;
  logic                   result_stall;
  logic [SAMPLE_BITS-1:0] average;
  logic                   last_out;

  window_average_predictor averages = new();

  bit          no_idle;
  int unsigned items_sent;
  int unsigned streams_closed;
  int unsigned cfg_writes;
  int unsigned quiet_cycles;
  int unsigned directed_items;
  int unsigned phase;
  int unsigned phase_start;

  centered_moving_average_unit #(
    .MAX_HALF   (MAX_HALF),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .half_width  (half_width),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample      (sample),
    .is_last     (is_last),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .average     (average),
    .last_out    (last_out)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: random stalls, none while no_idle is set
  always @(negedge clk) begin
    result_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      averages.check_average(average, last_out);
    end
  end

  always @(posedge clk) begin
    if (rst || (result_valid && !result_stall) || (sample_valid && !sample_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int unsigned sel;
    sel = $urandom_range(9);
    case (sel)
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3, 4: return SAMPLE_BITS'($urandom_range(40) - 20);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Present one sample and hold it until its transfer.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic last);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      sample_valid = 1'b0;
      @(negedge clk);
    end
    sample_valid = 1'b1;
    sample = s;
    is_last = last;
    do @(posedge clk); while (sample_stall);
    averages.note_sample(s, last);
    items_sent++;
    if (last) streams_closed++;
  endtask

  task automatic send_stream(input int unsigned count, input bit closed);
    for (int unsigned i = 0; i < count; i++) begin
      send_sample(pick_sample(), closed && (i == count - 1));
    end
  endtask

  // Wait for every expected average, then let the block settle.
  task automatic drain_results();
    @(negedge clk);
    sample_valid = 1'b0;
    while (averages.expected_averages.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_half_width(input int unsigned v);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    half_width = HW_BITS'(v);
    do @(posedge clk); while (!cfg_ready);
    averages.load_half_width(v);
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    half_width = '0;
    sample_valid = 1'b0;
    sample = '0;
    is_last = 1'b0;
    result_stall = 1'b0;
    no_idle = 1'b0;
    items_sent = 0;
    streams_closed = 0;
    cfg_writes = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset half width, full-scale swings
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b1);
    // one-sample stream
    send_sample(16'h8000, 1'b1);
    // window of one
    write_half_width(0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h0001, 1'b1);
    // widest window, stream shorter than it
    write_half_width(MAX_HALF);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    // drop an open stream with a register write
    write_half_width(2);
    send_sample(16'h1234, 1'b0);
    send_sample(16'hEDCB, 1'b0);
    write_half_width(3);
    // negative means truncate toward zero
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFE, 1'b0);
    send_sample(16'h0000, 1'b1);
    directed_items = items_sent;

    phase = 0;
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      case (phase)
        0: write_half_width(MAX_HALF);
        1: write_half_width(0);
        default: write_half_width($urandom_range(MAX_HALF));
      endcase
      no_idle = (phase == 2);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(7) == 0) begin
          send_stream($urandom_range(2 * averages.half + 6, 50), 1'b1);
        end else begin
          send_stream($urandom_range(1, 2 * averages.half + 6), 1'b1);
        end
      end
      // leave a stream open now and then; the next write drops it
      if ($urandom_range(3) == 0) begin
        send_stream($urandom_range(1, 2 * averages.half + 3), 1'b0);
      end
      no_idle = 1'b0;
      phase++;
    end

    drain_results();
    $display("Ran %0d samples in %0d closed streams under %0d half-width writes.",
             items_sent, streams_closed, cfg_writes);
    $display("Checked %0d averages, %0d mismatches.", averages.checked,
             averages.mismatches);
    if (averages.mismatches == 0 && averages.expected_averages.size() == 0) begin
      $display("TB_OK");
    end else begin
      if (averages.expected_averages.size() != 0) begin
        $display("%0t: %0d expected averages never arrived", $time,
                 averages.expected_averages.size());
      end
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
